@@ rtl/core/dcdd_pkg.sv @@
package dcdd_pkg;

  localparam int unsigned CountWidth = 16;
  localparam int unsigned DigitWidth = 4;
  localparam int unsigned NumDigits  = 4;
  localparam int unsigned NumLanes   = 2;
  localparam int unsigned NumFrames  = NumDigits * NumLanes;
  localparam int unsigned FrameIdxW  = $clog2(NumFrames);
  localparam int unsigned PosWidth   = 4;

  // Reciprocal of ten, exact for every 16-bit dividend after a shift by 19
  localparam logic [31:0] RecipTen   = 32'd52429;
  localparam int unsigned RecipShift = 19;

  localparam logic [DigitWidth-1:0] MaxDigit = 4'd9;
  localparam logic [PosWidth-1:0]   LastPos  = 4'd8;

  typedef logic [CountWidth-1:0]   count_t;
  typedef logic [DigitWidth-1:0]   digit_t;
  typedef logic [PosWidth-1:0]     pos_t;
  typedef logic [FrameIdxW-1:0]    frame_idx_t;
  typedef digit_t [NumDigits-1:0]  digits_t;
  typedef count_t [NumLanes-1:0]   count_pair_t;
  typedef digits_t [NumLanes-1:0]  digit_pair_t;

  // Quotient by ten through multiply and shift
  function automatic count_t div10(count_t x);
    logic [31:0] prod;
    prod = 32'(x) * RecipTen;
    return count_t'(prod >> RecipShift);
  endfunction

  // Remainder digit from the low nibbles of dividend and quotient
  function automatic digit_t rem_digit(digit_t x_lo, digit_t q_lo);
    digit_t tenq;
    tenq = digit_t'({q_lo, 3'b000}) + digit_t'({q_lo, 1'b0});
    return digit_t'(x_lo - tenq);
  endfunction

endpackage

@@ rtl/core/dcdd_req_if.sv @@
interface dcdd_req_if import dcdd_pkg::*; ();
  logic   valid;
  logic   ready;
  count_t current_count;
  count_t target_count;

  modport source (output valid, current_count, target_count, input ready);
  modport sink (input valid, current_count, target_count, output ready);
endinterface

@@ rtl/core/dcdd_frame_if.sv @@
interface dcdd_frame_if import dcdd_pkg::*; ();
  logic   valid;
  logic   ready;
  pos_t   digit_position;
  digit_t digit_value;
  logic   last_frame;

  modport source (output valid, digit_position, digit_value, last_frame, input ready);
  modport sink (input valid, digit_position, digit_value, last_frame, output ready);
endinterface

@@ rtl/core/dcdd_bcd_pipe.sv @@
module dcdd_bcd_pipe import dcdd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  count_pair_t count_i,
  output logic        valid_o,
  output digit_pair_t digits_o
);

  localparam int unsigned NumStages = 5;

  logic [NumStages-1:0] vld_q;

  // Per-stage quotients, narrowed to what each can hold
  logic [12:0] q1_q [NumLanes];
  logic [9:0]  q2_q [NumLanes];
  logic [6:0]  q3_q [NumLanes];
  logic [2:0]  q4_q [NumLanes];
  digit_t      lo_s1_q [NumLanes];
  digit_t      lo_s2_q [NumLanes];
  digit_t      lo_s3_q [NumLanes];
  digit_t      lo_s4_q [NumLanes];
  digits_t     dig_s2_q [NumLanes];
  digits_t     dig_s3_q [NumLanes];
  digits_t     dig_s4_q [NumLanes];
  digits_t     dig_s5_q [NumLanes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NumStages-2:0], valid_i};
    end
  end

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        // stage 1: first quotient
        q1_q[l]    <= 13'(div10(count_i[l]));
        lo_s1_q[l] <= count_i[l][DigitWidth-1:0];
        // stage 2: units digit, second quotient
        q2_q[l]       <= 10'(div10(count_t'(q1_q[l])));
        lo_s2_q[l]    <= q1_q[l][DigitWidth-1:0];
        dig_s2_q[l]   <= {digit_t'(0), digit_t'(0), digit_t'(0),
                          rem_digit(lo_s1_q[l], q1_q[l][DigitWidth-1:0])};
        // stage 3: tens digit
        q3_q[l]       <= 7'(div10(count_t'(q2_q[l])));
        lo_s3_q[l]    <= q2_q[l][DigitWidth-1:0];
        dig_s3_q[l]   <= {dig_s2_q[l][3:2],
                          rem_digit(lo_s2_q[l], q2_q[l][DigitWidth-1:0]),
                          dig_s2_q[l][0]};
        // stage 4: hundreds digit; drop anything past thousands
        q4_q[l]       <= 3'(div10(count_t'(q3_q[l])));
        lo_s4_q[l]    <= q3_q[l][DigitWidth-1:0];
        dig_s4_q[l]   <= {dig_s3_q[l][3],
                          rem_digit(lo_s3_q[l], q3_q[l][DigitWidth-1:0]),
                          dig_s3_q[l][1:0]};
        // stage 5: thousands digit
        dig_s5_q[l]   <= {rem_digit(lo_s4_q[l], {1'b0, q4_q[l]}),
                          dig_s4_q[l][2:0]};
      end
    end
    assign digits_o[l] = dig_s5_q[l];
  end

  assign valid_o = vld_q[NumStages-1];

endmodule

@@ rtl/core/dual_count_display_digits.sv @@
// Flow: an accepted request passes the digit pipeline, then the serializer
// sends its frames one per cycle while frame_o.ready is high, eight in all.
// Throughput: set by the frame serializer, one frame a cycle while ready is high;
// the five-stage digit pipeline takes a request every cycle unless its last stage
// waits on the serializer, and holds up to five while the serializer drains.
// Reset: asynchronous, active low; clears all valid bits and the serializer's busy flag and index.
module dual_count_display_digits import dcdd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  dcdd_req_if.sink     req_i,
  dcdd_frame_if.source frame_o
);

  // Pipeline side
  logic        pipe_en;
  logic        pipe_vld;
  count_pair_t pipe_count;
  digit_pair_t pipe_digits;

  // Serializer side
  logic        busy_q, busy_d;
  frame_idx_t  idx_q, idx_d;
  digit_pair_t dig_q;
  logic        frame_beat;
  logic        frame_last;
  logic        ser_load;

  assign frame_last = (idx_q == frame_idx_t'(NumFrames - 1));
  assign frame_beat = frame_o.valid && frame_o.ready;

  // Take a new digit set when empty or while the final frame leaves
  assign ser_load = !busy_q || (frame_beat && frame_last);

  // Advance the pipe whenever its last stage is empty or gets drained
  assign pipe_en     = !pipe_vld || ser_load;
  assign req_i.ready = pipe_en;

  assign pipe_count[0] = req_i.current_count;
  assign pipe_count[1] = req_i.target_count;

  dcdd_bcd_pipe u_pipe (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (pipe_en),
    .valid_i  (req_i.valid),
    .count_i  (pipe_count),
    .valid_o  (pipe_vld),
    .digits_o (pipe_digits)
  );

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (ser_load) begin
      busy_d = pipe_vld;
      idx_d  = '0;
    end else if (frame_beat) begin
      idx_d = idx_q + frame_idx_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  // Hold the digit set for the whole run
  always_ff @(posedge clk_i) begin
    if (ser_load && pipe_vld) begin
      dig_q <= pipe_digits;
    end
  end

  // Upper index bit picks the count, lower bits pick units..thousands
  assign frame_o.valid          = busy_q;
  assign frame_o.digit_position = pos_t'(idx_q) + pos_t'(1);
  assign frame_o.digit_value    = dig_q[idx_q[FrameIdxW-1]][idx_q[FrameIdxW-2:0]];
  assign frame_o.last_frame     = frame_last;

  a_digit_decimal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_o.valid |-> (frame_o.digit_value <= MaxDigit))
    else $error("digit out of decimal range");

  a_last_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_o.valid && frame_o.last_frame) |-> (frame_o.digit_position == LastPos))
    else $error("last frame flagged away from final position");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_beat && !frame_o.last_frame) |=>
      (frame_o.valid &&
       frame_o.digit_position == pos_t'($past(frame_o.digit_position) + pos_t'(1))))
    else $error("frame run broken before final frame");

  a_pipe_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pipe_vld && !ser_load) |=> pipe_vld)
    else $error("pipeline result lost during stall");

endmodule

@@ sim/dual_count_display_digits_tb.sv @@
`timescale 1ns / 100ps

module dual_count_display_digits_tb;
  import dcdd_pkg::*;

  // Cycles without any beat on either channel before the run is called hung.
  // The slowest legal gap comes from a sender or receiver that idles 86% of
  // the time, so this leaves a wide margin.
  localparam int unsigned StallLimit = 2000;
  // Cycles to watch for stray frames once nothing is expected any more
  localparam int unsigned TailCycles = 20;
  localparam int unsigned NumDirected = 16;

  typedef struct {
    pos_t   pos;
    digit_t value;
    logic   last;
  } frame_t;

  // Expected display frames, oldest first, plus the mismatch tally
  class digit_frame_board;
    frame_t      frame_q[$];
    int unsigned errors;

    // Split both counts into their four low decimal digits, units first.
    function void note_request(count_t current, count_t target);
      count_t      lane [NumLanes];
      frame_t      f;
      int unsigned scale;
      lane[0] = current;
      lane[1] = target;
      for (int l = 0; l < NumLanes; l++) begin
        scale = 1;
        for (int d = 0; d < NumDigits; d++) begin
          f.pos   = pos_t'(l * NumDigits + d + 1);
          f.value = digit_t'((int'(lane[l]) / scale) % 10);
          f.last  = (l == NumLanes - 1) && (d == NumDigits - 1);
          frame_q.push_back(f);
          scale = scale * 10;
        end
      end
    endfunction

    function void check_frame(pos_t pos, digit_t value, logic last);
      frame_t want;
      if (frame_q.size() == 0) begin
        $display("%0t: unexpected frame pos %0d value %0d last %0b",
                 $time, pos, value, last);
        errors++;
        return;
      end
      want = frame_q.pop_front();
      if (pos !== want.pos) begin
        $display("%0t: digit_position expected %0d actual %0d", $time, want.pos, pos);
        errors++;
      end
      if (value !== want.value) begin
        $display("%0t: digit_value at pos %0d expected %0d actual %0d",
                 $time, want.pos, want.value, value);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last_frame at pos %0d expected %0b actual %0b",
                 $time, want.pos, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  dcdd_req_if   req_if ();
  dcdd_frame_if frame_if ();

  dual_count_display_digits i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if.sink),
    .frame_o(frame_if.source)
  );

  digit_frame_board board = new();

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned quiet_cycles;

  // Directed pairs: all zeros and all ones, the largest four-digit value and
  // the first five-digit one (ten-thousands digit dropped), alternating bit
  // patterns, every digit position lit in turn, and each lane at an extreme
  // while the other sits at the opposite one.
  count_t dir_current [NumDirected] = '{
    16'd0, 16'd65535, 16'd9999, 16'd10000, 16'd1234, 16'd65535, 16'd0,
    16'd12345, 16'h5555, 16'hAAAA, 16'd1, 16'd100, 16'd9, 16'd999,
    16'd20000, 16'd10009
  };
  count_t dir_target [NumDirected] = '{
    16'd0, 16'd65535, 16'd9999, 16'd10000, 16'd5678, 16'd0, 16'd65535,
    16'd54321, 16'hAAAA, 16'h5555, 16'd10, 16'd1000, 16'd99, 16'd10001,
    16'd30000, 16'd59990
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hold every input at a known value from time zero, then release reset.
  initial begin
    rst_n                 = 1'b0;
    req_if.valid          = 1'b0;
    req_if.current_count  = '0;
    req_if.target_count   = '0;
    frame_if.ready        = 1'b0;
    send_idle_pct         = 0;
    recv_idle_pct         = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Receiver: stall at random, one roll per cycle.
  always @(posedge clk) begin
    frame_if.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // Record request beats and check frame beats. Values read here are the
  // ones present just before the edge, so both sides see the same beat.
  always @(posedge clk) begin
    if (rst_n && req_if.valid && req_if.ready) begin
      board.note_request(req_if.current_count, req_if.target_count);
    end
    if (rst_n && frame_if.valid && frame_if.ready) begin
      board.check_frame(frame_if.digit_position, frame_if.digit_value,
                        frame_if.last_frame);
    end
  end

  // Watchdog: abort when neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (!rst_n || (req_if.valid && req_if.ready) ||
        (frame_if.valid && frame_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Half are full-range counts; the rest cluster below 10000, around the
  // multiples of 10000 and just under the top of the range.
  function automatic count_t pick_count();
    case ($urandom_range(5))
      0, 1, 2: return count_t'($urandom);
      3:       return count_t'($urandom_range(9999));
      4:       return count_t'($urandom_range(6, 1) * 10000 + $urandom_range(18) - 9);
      default: return count_t'(65535 - $urandom_range(15));
    endcase
  endfunction

  // Present one request and wait for its beat. Valid stays high on return so
  // a back-to-back request needs no second assignment in the same step.
  // Must be called right after a rising edge.
  task automatic send_request(input count_t current, input count_t target);
    if ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_if.valid         <= 1'b1;
    req_if.current_count <= current;
    req_if.target_count  <= target;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // Drop valid and hold off until every expected frame has come out.
  task automatic drain_frames();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (board.frame_q.size() != 0);
  endtask

  task automatic run_random(input int unsigned count);
    repeat (count) send_request(pick_count(), pick_count());
  endtask

  initial begin
    wait (rst_n === 1'b1);
    @(posedge clk);

    // Phase 1: sender idles now and then, receiver mostly stalls
    send_idle_pct = 36;
    recv_idle_pct = 86;
    for (int i = 0; i < NumDirected; i++) begin
      send_request(dir_current[i], dir_target[i]);
    end
    run_random(170);
    drain_frames();

    // Phase 2: roles swapped, so the pipeline mostly runs dry
    send_idle_pct = 86;
    recv_idle_pct = 36;
    run_random(170);
    drain_frames();

    // Phase 3: full speed on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(160);
    drain_frames();

    // Watch for stray frames past the pipeline latency
    repeat (TailCycles) @(posedge clk);
    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
